### rtl/core/near_even_parity_substring_counter_top_assert.svh
// Assertion shorthands shared by the counter's RTL files.
// Each expects clk_i and the active-low reset rst_ni in scope.
`ifndef NEAR_EVEN_PARITY_SUBSTRING_COUNTER_TOP_ASSERT_SVH
`define NEAR_EVEN_PARITY_SUBSTRING_COUNTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NEPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NEPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nepsc_pkg.sv
package nepsc_pkg;

  localparam int unsigned ALPHABET_DEF = 10;
  localparam int unsigned LETTER_W     = 4;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned EPOCH_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic sweep;
    logic rd_issue;
    logic wr;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first;
    logic letter_ok;
    logic epoch_full;
    logic sweep_last;
    logic nb_last;
  } sts_t;

endpackage

### rtl/core/nepsc_if.sv
interface nepsc_in_if;
  import nepsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter;
  logic                first_of_string;

  modport source (output valid, output letter, output first_of_string, input ready);
  modport sink   (input valid, input letter, input first_of_string, output ready);
endinterface

interface nepsc_out_if;
  import nepsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] running_total;

  modport source (output valid, output running_total, input ready);
  modport sink   (input valid, input running_total, output ready);
endinterface

### rtl/core/nepsc_dpath.sv
`include "near_even_parity_substring_counter_top_assert.svh"

module nepsc_dpath #(
  parameter int unsigned ALPHABET = nepsc_pkg::ALPHABET_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nepsc_pkg::cmd_t                 cmd_i,
  output nepsc_pkg::sts_t                 sts_o,
  input  logic [nepsc_pkg::LETTER_W-1:0]  letter_i,
  input  logic                            first_i,
  output logic [nepsc_pkg::TOTAL_W-1:0]   running_total_o
);
  import nepsc_pkg::*;

  localparam int unsigned Depth   = 2 ** ALPHABET;
  localparam int unsigned NbW     = $clog2(ALPHABET + 1);
  localparam int unsigned EntryW  = EPOCH_W + COUNT_W;

  typedef logic [ALPHABET-1:0] mask_t;

  // histogram entry: {epoch, count}; an entry from an older epoch reads as reset
  logic [EntryW-1:0]   hist_mem [Depth];

  logic [LETTER_W-1:0] letter_q;
  logic                first_q;
  mask_t               mask_q, sw_addr_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [NbW-1:0]      nb_q;
  logic [TOTAL_W-1:0]  total_q, acc_q, out_total_q;
  logic [COUNT_W-1:0]  self_q;
  logic [EntryW-1:0]   rd_data_q;
  logic                rd_vld_q, rd_self_q, rd_zero_q;

  mask_t               mask_base, letter_bit, nb_bit, rd_addr, wr_addr;
  logic                letter_ok;
  logic [EntryW-1:0]   wr_data;
  logic                wr_en;
  logic [COUNT_W-1:0]  self_inc, rd_val;
  logic [TOTAL_W:0]    acc_sum;

  assign letter_ok  = {1'b0, letter_q} < (LETTER_W + 1)'(ALPHABET);
  assign mask_base  = first_q ? '0 : mask_q;
  assign letter_bit = mask_t'(1) << letter_q;
  assign nb_bit     = mask_t'(1) << (nb_q - NbW'(1));
  assign rd_addr    = (nb_q == '0) ? mask_q : (mask_q ^ nb_bit);

  assign self_inc = (self_q == COUNT_MAX) ? self_q : self_q + COUNT_W'(1);
  assign wr_en    = cmd_i.sweep | cmd_i.wr;
  assign wr_addr  = cmd_i.sweep ? sw_addr_q : mask_q;
  assign wr_data  = cmd_i.sweep ? '0 : {epoch_q, self_inc};

  assign rd_val  = (rd_data_q[EntryW-1:COUNT_W] == epoch_q) ? rd_data_q[COUNT_W-1:0]
                                                            : {{(COUNT_W-1){1'b0}}, rd_zero_q};
  assign acc_sum = {1'b0, acc_q} + (TOTAL_W + 1)'(rd_val);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      letter_q <= letter_i;
      first_q  <= first_i;
    end
    if (cmd_i.rd_issue) begin
      rd_zero_q <= (rd_addr == '0);
    end
    if (cmd_i.prep) begin
      acc_q <= first_q ? '0 : total_q;
    end else if (rd_vld_q) begin
      acc_q <= acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
    end
    if (rd_self_q) begin
      self_q <= rd_val;
    end
    if (cmd_i.load_out) begin
      out_total_q <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      total_q   <= '0;
      epoch_q   <= EPOCH_W'(1);
      sw_addr_q <= '0;
      nb_q      <= '0;
      rd_vld_q  <= 1'b0;
      rd_self_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_issue;
      rd_self_q <= cmd_i.rd_issue && (nb_q == '0);
      if (cmd_i.sweep) begin
        sw_addr_q <= sw_addr_q + mask_t'(1);
      end
      if (cmd_i.prep) begin
        nb_q   <= '0;
        mask_q <= letter_ok ? (mask_base ^ letter_bit) : mask_base;
        if (first_q) begin
          total_q <= '0;
          // a wrapped epoch would alias old entries: restart at one after a sweep
          epoch_q <= (&epoch_q) ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
        end
      end else if (cmd_i.rd_issue) begin
        nb_q <= nb_q + NbW'(1);
      end
      if (cmd_i.wr) begin
        total_q <= acc_q;
      end
    end
  end

  assign sts_o.first      = first_q;
  assign sts_o.letter_ok  = letter_ok;
  assign sts_o.epoch_full = &epoch_q;
  assign sts_o.sweep_last = &sw_addr_q;
  assign sts_o.nb_last    = (nb_q == NbW'(ALPHABET));

  assign running_total_o = out_total_q;

  `NEPSC_ASSERT_NEXT(a_total_monotonic, !cmd_i.prep, total_q >= $past(total_q), "total decreased without a start")
  `NEPSC_ASSERT_NOW(a_no_rw_overlap, cmd_i.wr, !cmd_i.rd_issue && !cmd_i.sweep, "write-back collides with read or sweep")
  `NEPSC_ASSERT_NEXT(a_self_first, cmd_i.prep, nb_q == '0, "neighbor scan does not start at the mask itself")

endmodule

### rtl/core/nepsc_ctrl.sv
`include "near_even_parity_substring_counter_top_assert.svh"

module nepsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  nepsc_pkg::sts_t sts_i,
  output nepsc_pkg::cmd_t cmd_o
);
  import nepsc_pkg::*;

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       resume_q, resume_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    resume_d   = resume_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          resume_d = 1'b0;
          if (!resume_q) begin
            state_d = ST_IDLE;
          end else if (sts_i.letter_ok) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.first && sts_i.epoch_full) begin
          state_d  = ST_SWEEP;
          resume_d = 1'b1;
        end else if (sts_i.letter_ok) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.nb_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      resume_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      resume_q    <= resume_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `NEPSC_ASSERT_NOW(a_no_overwrite, cmd_o.load_out, !out_valid_q || out_ready_i, "pending result overwritten")
  `NEPSC_ASSERT_NEXT(a_accept_prep, in_valid_i && in_ready_o, state_q == ST_PREP, "transfer not followed by prep")
  `NEPSC_ASSERT_NEXT(a_read_end, (state_q == ST_READ) && sts_i.nb_last, state_q == ST_DRAIN, "read scan overran")

endmodule

### rtl/core/near_even_parity_substring_counter_top.sv
// Near-even-parity substring counter.
// Input channel in_i carries one letter code (letter, 0 up to ALPHABET-1) and
// first_of_string; a transfer takes place when valid and ready are both high.
// first_of_string clears the parity mask, histogram and total before the letter
// is used. A letter code of ALPHABET or more leaves the state unchanged.
// Output channel out_o carries one running_total per input transfer, in order:
// the count of substrings so far with at most one letter of odd occurrence.
// Each letter takes ALPHABET+1 histogram reads (the mask and its neighbors)
// and one write-back, in sequence; ready stays low until the result is loaded,
// so the block does not take a new letter while one is still in progress.
// An out-of-range letter skips the reads and the write-back.
// Reset: a clearing pass over all 2**ALPHABET entries (1024 by default) sweeps
// the histogram with ready held low. Starts are tracked with an epoch mark;
// every 255th start repeats that pass before the item goes on.
// A stalled receiver holds the result in the output register; the block still
// takes the next item and waits before loading its result.
module near_even_parity_substring_counter_top #(
  parameter int unsigned ALPHABET = nepsc_pkg::ALPHABET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nepsc_in_if.sink    in_i,
  nepsc_out_if.source out_o
);
  import nepsc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // sequencing: sweep, accept, scan the mask and its neighbors, write back
  nepsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // mask, histogram memory, accumulator and output register
  nepsc_dpath #(
    .ALPHABET(ALPHABET)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .letter_i       (in_i.letter),
    .first_i        (in_i.first_of_string),
    .running_total_o(out_o.running_total)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
